### hdl/pvm_pkg.sv
// Shared types, constants and tables for the varicode phase-shift modulator.
// Used by every module of the block; depends on nothing.
package pvm_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int SINE_ADDR_BITS = 10;
    localparam int QA_BITS        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_BITS        = $clog2(QUEUE_DEPTH + 1);
    localparam int SINE_LAT       = 6;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    localparam logic [2:0] REG_CARRIER_STEP = 3'd0;
    localparam logic [2:0] REG_SYMBOL_LEN   = 3'd1;
    localparam logic [2:0] REG_FRAC_STEP    = 3'd2;
    localparam logic [2:0] REG_QPSK_MODE    = 3'd3;
    localparam logic [2:0] REG_INVERT_BITS  = 3'd4;
    localparam logic [2:0] REG_TAIL_BITS    = 3'd5;

    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_TEXT = 2'd1;
    localparam logic [1:0] PH_POST = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam logic [31:0] RST_CARRIER_STEP = 32'd89478485;
    localparam logic [20:0] RST_SYMBOL_LEN   = 21'd393216;
    localparam logic [21:0] RST_FRAC_STEP    = 22'd10923;
    localparam logic [7:0]  RST_TAIL_BITS    = 8'd64;

    localparam logic [24:0] FRAC_ONE = 25'd16777216;

    localparam logic signed [35:0] Q30 = 36'sd1073741824;
    localparam logic signed [35:0] C1  = 36'sd1686629713;
    localparam logic signed [35:0] C3  = -36'sd693598668;
    localparam logic signed [35:0] C5  = 36'sd85569305;
    localparam logic signed [35:0] C7  = -36'sd5026995;
    localparam logic signed [35:0] C9  = 36'sd172273;
    localparam logic [14:0] AMPLITUDE  = 15'd19005;

    localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - SINE_ADDR_BITS)) - 32'd1);

    typedef struct packed {
        logic [31:0] carrier_step;
        logic [20:0] symbol_len_q8;
        logic [21:0] frac_step;
        logic        qpsk_mode;
        logic        invert_bits;
        logic [7:0]  tail_bits;
    } cfg_t;

    typedef struct packed {
        logic       nonempty;
        logic [7:0] head;
    } qstat_t;

    typedef struct packed {
        logic [11:0] code_shift;
        logic [3:0]  bits_left;
        logic [7:0]  tail_count;
        logic [1:0]  pom;
    } bit_state_t;

    typedef struct packed {
        bit_state_t bs;
        logic       bit_v;
        logic       ok;
        logic       pop;
    } pull_t;

    typedef struct packed {
        logic        vld;
        logic        smp;
        logic        full;
        logic        fin;
        logic [31:0] cos_ph;
        logic [31:0] base;
        logic [1:0]  delta;
    } synth_in_t;

    localparam logic [9:0] VARICODE [0:127] = '{
        10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
        10'd0, 10'd239, 10'd29, 10'd0, 10'd0, 10'd31, 10'd0, 10'd0,
        10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
        10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
        10'd1, 10'd511, 10'd351, 10'd501, 10'd475, 10'd725, 10'd699, 10'd383,
        10'd251, 10'd247, 10'd367, 10'd479, 10'd117, 10'd53, 10'd87, 10'd431,
        10'd183, 10'd189, 10'd237, 10'd255, 10'd375, 10'd347, 10'd363, 10'd429,
        10'd427, 10'd439, 10'd245, 10'd445, 10'd493, 10'd85, 10'd471, 10'd687,
        10'd701, 10'd125, 10'd235, 10'd173, 10'd181, 10'd119, 10'd219, 10'd253,
        10'd341, 10'd127, 10'd509, 10'd381, 10'd215, 10'd187, 10'd221, 10'd171,
        10'd213, 10'd477, 10'd175, 10'd111, 10'd109, 10'd343, 10'd437, 10'd349,
        10'd373, 10'd379, 10'd685, 10'd503, 10'd495, 10'd507, 10'd703, 10'd365,
        10'd735, 10'd11, 10'd95, 10'd47, 10'd45, 10'd3, 10'd61, 10'd91,
        10'd43, 10'd13, 10'd491, 10'd191, 10'd27, 10'd59, 10'd15, 10'd7,
        10'd63, 10'd447, 10'd21, 10'd23, 10'd5, 10'd55, 10'd123, 10'd107,
        10'd223, 10'd93, 10'd469, 10'd695, 10'd443, 10'd693, 10'd727, 10'd0
    };

endpackage

### hdl/pvm_front.sv
// Front end: character queue with CR/CRLF folding and the full flag.
// Depends on pvm_pkg.
module pvm_front
    import pvm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       append,
    input  logic [7:0] char_code,
    input  logic       pop,
    output qstat_t     qstat,
    output logic       refused
);

    logic [7:0]         mem_reg [QUEUE_DEPTH];
    logic [QA_BITS-1:0] head_reg, head_next;
    logic [QA_BITS-1:0] tail_reg, tail_next;
    logic [QC_BITS-1:0] count_reg, count_next;
    logic               prev_cr_reg, prev_cr_next;
    logic               drop_lf, can_push, push;

    function automatic logic [QA_BITS-1:0] next_ptr(input logic [QA_BITS-1:0] p);
        next_ptr = (p == QA_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign drop_lf  = (char_code == CHAR_LF) && prev_cr_reg;
    assign can_push = (count_reg < QC_BITS'(QUEUE_DEPTH));
    assign push     = append && !drop_lf && can_push;
    assign refused  = append && !drop_lf && !can_push;

    assign qstat.nonempty = (count_reg != '0);
    assign qstat.head     = mem_reg[head_reg];

    always_comb
    begin
        head_next    = pop ? next_ptr(head_reg) : head_reg;
        tail_next    = push ? next_ptr(tail_reg) : tail_reg;
        count_next   = count_reg + QC_BITS'(push) - QC_BITS'(pop);
        prev_cr_next = prev_cr_reg;
        if (append)
        begin
            prev_cr_next = push && (char_code == CHAR_CR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            prev_cr_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            prev_cr_reg <= prev_cr_next;
        end
    end

    // A CR is stored as LF.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= (char_code == CHAR_CR) ? CHAR_LF : char_code;
        end
    end

endmodule

### hdl/pvm_sequencer.sv
// Back end control: bit source, differential symbol mapping and symbol timing.
// Depends on pvm_pkg; takes characters from pvm_front.
module pvm_sequencer
    import pvm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick,
    input  logic        end_set,
    input  cfg_t        cfg,
    input  qstat_t      qstat,
    output logic        pop,
    output logic        smp,
    output logic [31:0] cos_ph,
    output logic [31:0] base,
    output logic [1:0]  delta,
    output logic        fin
);

    bit_state_t  bs_reg, bs_next;
    logic        loaded_reg, loaded_next;
    logic [1:0]  step_reg, step_next;
    logic [1:0]  start_reg, start_next;
    logic [31:0] carrier_reg, carrier_next;
    logic [21:0] cnt_reg, cnt_next;
    logic [24:0] frac_reg, frac_next;
    logic        end_reg;

    logic [9:0]  vraw, vcode;
    logic [3:0]  vlen;
    logic [11:0] load_shift;
    logic [3:0]  load_len;
    pull_t       p1, p2;
    logic        b2, ok;
    logic [21:0] cnt1, cnt2;
    logic [24:0] frac1;
    logic [43:0] fprod;
    logic [35:0] fq;

    function automatic pull_t pull_bit(input bit_state_t s, input logic qne,
                                       input logic [11:0] lshift, input logic [3:0] llen,
                                       input logic endr, input cfg_t c);
        pull_t r;
        r.bs    = s;
        r.bit_v = c.invert_bits;
        r.ok    = 1'b0;
        r.pop   = 1'b0;
        if (r.bs.pom == PH_PRE)
        begin
            if (r.bs.tail_count < c.tail_bits)
            begin
                r.bs.tail_count = r.bs.tail_count + 8'd1;
                r.ok = 1'b1;
            end
            else
            begin
                r.bs.pom        = PH_TEXT;
                r.bs.tail_count = '0;
            end
        end
        if (!r.ok && r.bs.pom == PH_TEXT)
        begin
            if (r.bs.bits_left == 4'd0 && qne)
            begin
                r.bs.code_shift = lshift;
                r.bs.bits_left  = llen;
                r.pop = 1'b1;
            end
            if (r.bs.bits_left != 4'd0)
            begin
                r.bs.bits_left = r.bs.bits_left - 4'd1;
                r.bit_v = r.bs.code_shift[r.bs.bits_left] ^ c.invert_bits;
                r.ok = 1'b1;
            end
            else if (!endr)
            begin
                r.ok = 1'b1;
            end
            else
            begin
                r.bs.pom        = PH_POST;
                r.bs.tail_count = '0;
            end
        end
        if (!r.ok && r.bs.pom == PH_POST)
        begin
            if (r.bs.tail_count < c.tail_bits)
            begin
                r.bs.tail_count = r.bs.tail_count + 8'd1;
                r.ok = 1'b1;
            end
            else
            begin
                r.bs.pom = PH_DONE;
            end
        end
        return r;
    endfunction

    // Characters without a code are sent as space.
    always_comb
    begin
        vraw  = qstat.head[7] ? 10'd0 : VARICODE[qstat.head[6:0]];
        vcode = (vraw == 10'd0) ? 10'd1 : vraw;
        vlen  = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (vcode[i])
            begin
                vlen = 4'(i + 1);
            end
        end
        load_shift = {vcode, 2'b00};
        load_len   = vlen + 4'd2;
    end

    always_comb
    begin
        bs_next      = bs_reg;
        loaded_next  = loaded_reg;
        step_next    = step_reg;
        start_next   = start_reg;
        carrier_next = carrier_reg;
        cnt_next     = cnt_reg;
        frac_next    = frac_reg;
        p1  = pull_bit(bs_reg, qstat.nonempty, load_shift, load_len, end_reg, cfg);
        p2  = pull_bit(p1.bs, qstat.nonempty && !p1.pop, load_shift, load_len, end_reg, cfg);
        b2  = p2.ok ? p2.bit_v : 1'b1;
        ok  = 1'b0;
        pop = 1'b0;
        cnt1  = cnt_reg + 22'd256;
        frac1 = frac_reg + 25'(cfg.frac_step);
        cnt2  = cnt1 - 22'(cfg.symbol_len_q8);
        if (cnt2 >= 22'(cfg.symbol_len_q8))
        begin
            cnt2 = '0;
        end
        fprod = 44'(cnt2) * 44'(cfg.frac_step);
        fq    = fprod[43:8];
        if (tick)
        begin
            if (loaded_reg)
            begin
                ok = 1'b1;
            end
            else
            begin
                bs_next = p1.bs;
                pop     = p1.pop;
                if (p1.ok)
                begin
                    ok = 1'b1;
                    if (cfg.qpsk_mode)
                    begin
                        bs_next = p2.bs;
                        pop     = p1.pop || p2.pop;
                        case ({p1.bit_v, b2})
                            2'b11:   step_next = 2'd0;
                            2'b01:   step_next = 2'd1;
                            2'b10:   step_next = 2'd3;
                            default: step_next = 2'd2;
                        endcase
                    end
                    else
                    begin
                        step_next = p1.bit_v ? 2'd0 : 2'd2;
                    end
                end
            end
            if (ok)
            begin
                carrier_next = carrier_reg + cfg.carrier_step;
                loaded_next  = 1'b1;
                frac_next    = (frac1 > FRAC_ONE) ? FRAC_ONE : frac1;
                cnt_next     = cnt1;
                if (cnt1 >= 22'(cfg.symbol_len_q8))
                begin
                    start_next  = start_reg + step_next;
                    cnt_next    = cnt2;
                    frac_next   = (fq > 36'(FRAC_ONE)) ? FRAC_ONE : fq[24:0];
                    loaded_next = 1'b0;
                end
            end
        end
    end

    assign smp    = ok;
    assign cos_ph = {frac_reg, 7'b0} + 32'h4000_0000;
    assign base   = carrier_reg + {start_reg, 30'b0};
    assign delta  = step_next;
    assign fin    = (bs_next.pom == PH_DONE) && !loaded_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg      <= '{code_shift: '0, bits_left: '0, tail_count: '0, pom: PH_PRE};
            loaded_reg  <= 1'b0;
            step_reg    <= '0;
            start_reg   <= '0;
            carrier_reg <= '0;
            cnt_reg     <= '0;
            frac_reg    <= '0;
            end_reg     <= 1'b0;
        end
        else
        begin
            bs_reg      <= bs_next;
            loaded_reg  <= loaded_next;
            step_reg    <= step_next;
            start_reg   <= start_next;
            carrier_reg <= carrier_next;
            cnt_reg     <= cnt_next;
            frac_reg    <= frac_next;
            if (end_set)
            begin
                end_reg <= 1'b1;
            end
        end
    end

endmodule

### hdl/pvm_sine.sv
// Pipelined quarter-wave sine: odd polynomial in Q30, one multiply per stage.
// Depends on pvm_pkg.
module pvm_sine
    import pvm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        ph,
    output logic signed [31:0] sin_val
);

    logic [30:0]        x_reg    [0:4];
    logic [1:0]         quad_reg [0:4];
    logic [30:0]        x2_reg   [0:3];
    logic signed [35:0] p_reg    [1:4];
    logic signed [31:0] out_reg;
    logic [30:0]        x_c;
    logic [61:0]        xx;
    logic signed [35:0] pf, pc;

    // Products are truncated toward zero, as integer division would.
    function automatic logic signed [35:0] mulq(input logic signed [35:0] a,
                                                input logic [30:0] b);
        logic signed [67:0] prod;
        logic [67:0]        mag;
        logic [67:0]        q;
        prod = 68'(a) * 68'($signed({1'b0, b}));
        mag  = prod[67] ? 68'(-prod) : 68'(prod);
        q    = mag >> 30;
        mulq = prod[67] ? -$signed(q[35:0]) : $signed(q[35:0]);
    endfunction

    always_comb
    begin
        x_c = ph[30] ? (31'h4000_0000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
        xx  = 62'(x_c) * 62'(x_c);
        pf  = mulq(p_reg[4], x_reg[4]);
        pc  = pf;
        if (pf > Q30)
        begin
            pc = Q30;
        end
        if (pf < 36'sd0)
        begin
            pc = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_c;
            quad_reg[0] <= ph[31:30];
            x2_reg[0]   <= xx[60:30];
            for (int i = 1; i < 5; i++)
            begin
                x_reg[i]    <= x_reg[i-1];
                quad_reg[i] <= quad_reg[i-1];
            end
            for (int i = 1; i < 4; i++)
            begin
                x2_reg[i] <= x2_reg[i-1];
            end
            p_reg[1] <= C7 + mulq(C9, x2_reg[0]);
            p_reg[2] <= C5 + mulq(p_reg[1], x2_reg[1]);
            p_reg[3] <= C3 + mulq(p_reg[2], x2_reg[2]);
            p_reg[4] <= C1 + mulq(p_reg[3], x2_reg[3]);
            out_reg  <= quad_reg[4][1] ? -pc[31:0] : pc[31:0];
        end
    end

    assign sin_val = out_reg;

endmodule

### hdl/pvm_synth.sv
// Sample pipeline: shaping cosine, data phase sum, output sine and scaling.
// Depends on pvm_pkg and pvm_sine.
module pvm_synth
    import pvm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  synth_in_t   si,
    output logic        out_vld,
    output logic [15:0] sample,
    output logic        sample_valid,
    output logic        queue_full,
    output logic        finished
);

    synth_in_t          sa_reg [0:SINE_LAT];
    synth_in_t          sb_reg [0:SINE_LAT];
    synth_in_t          sx_reg;
    logic               sa_vld_reg [0:SINE_LAT];
    logic               sb_vld_reg [0:SINE_LAT];
    logic               sx_vld_reg;
    logic [31:0]        ph_m_reg;
    logic signed [31:0] cosv, sinv;
    logic signed [32:0] diff;
    logic [30:0]        shaped;
    logic [31:0]        dterm;
    logic [31:0]        mag;
    logic [46:0]        scaled;
    logic [14:0]        amp_reg;
    logic               neg_reg;
    logic               vld_reg;
    logic [15:0]        sample_reg;
    logic               sv_reg, full_reg, fin_reg;

    pvm_sine u_cos (.clk(clk), .en(en), .ph(sa_reg[0].cos_ph), .sin_val(cosv));
    pvm_sine u_sin (.clk(clk), .en(en), .ph(ph_m_reg), .sin_val(sinv));

    always_comb
    begin
        diff   = 33'sd1073741824 - 33'(cosv);
        shaped = diff[31:1];
        case (sa_reg[SINE_LAT].delta)
            2'd1:    dterm = {1'b0, shaped};
            2'd2:    dterm = {shaped, 1'b0};
            2'd3:    dterm = -{1'b0, shaped};
            default: dterm = '0;
        endcase
        mag    = sinv[31] ? 32'(-sinv) : 32'(sinv);
        scaled = 47'(mag) * 47'(AMPLITUDE) + 47'h2000_0000;
    end

    // Valid bits of all stages reset; the wide payload needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SINE_LAT; i++)
            begin
                sa_vld_reg[i] <= 1'b0;
                sb_vld_reg[i] <= 1'b0;
            end
            sx_vld_reg <= 1'b0;
            vld_reg    <= 1'b0;
        end
        else if (en)
        begin
            sa_vld_reg[0] <= si.vld;
            sb_vld_reg[0] <= sa_vld_reg[SINE_LAT];
            for (int i = 1; i <= SINE_LAT; i++)
            begin
                sa_vld_reg[i] <= sa_vld_reg[i-1];
                sb_vld_reg[i] <= sb_vld_reg[i-1];
            end
            sx_vld_reg <= sb_vld_reg[SINE_LAT];
            vld_reg    <= sx_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg[0] <= si;
            sb_reg[0] <= sa_reg[SINE_LAT];
            for (int i = 1; i <= SINE_LAT; i++)
            begin
                sa_reg[i] <= sa_reg[i-1];
                sb_reg[i] <= sb_reg[i-1];
            end
            ph_m_reg <= (sa_reg[SINE_LAT].base + dterm) & PH_MASK;
            sx_reg   <= sb_reg[SINE_LAT];
            amp_reg  <= scaled[44:30];
            neg_reg  <= sinv[31];
            sample_reg <= !sx_reg.smp ? 16'd0 :
                          (neg_reg ? 16'(-{1'b0, amp_reg}) : {1'b0, amp_reg});
            sv_reg   <= sx_reg.smp;
            full_reg <= sx_reg.full;
            fin_reg  <= sx_reg.fin;
        end
    end

    assign out_vld      = vld_reg;
    assign sample       = sample_reg;
    assign sample_valid = sv_reg;
    assign queue_full   = full_reg;
    assign finished     = fin_reg;

endmodule

### hdl/psk31_varicode_modulator_core.sv
// Varicode BPSK/QPSK modulator: top level with configuration registers.
// Depends on pvm_pkg, pvm_front, pvm_sequencer and pvm_synth.
//
// Every item (append, sample tick, end request) gives one result, in order. An item
// is taken in every cycle while the result side keeps up; each result reaches the
// output through the 16 register stages of the sample pipeline (an input stage, two
// six-stage sine units, the phase-sum stage and two scaling stages). The whole
// pipeline holds when a result waits, so in_ready is high while out_ready is high or
// no result is waiting. The configuration port is always ready; write it only while
// no item is in flight.
module psk31_varicode_modulator_core
    import pvm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] sample,
    output logic        sample_valid,
    output logic        queue_full,
    output logic        finished,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t        cfg_reg;
    qstat_t      qstat;
    synth_in_t   si;
    logic        en, acc, pop, refused, smp, fin;
    logic [31:0] cos_ph, base;
    logic [1:0]  delta;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign acc       = in_valid && en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_step  <= RST_CARRIER_STEP;
            cfg_reg.symbol_len_q8 <= RST_SYMBOL_LEN;
            cfg_reg.frac_step     <= RST_FRAC_STEP;
            cfg_reg.qpsk_mode     <= 1'b0;
            cfg_reg.invert_bits   <= 1'b0;
            cfg_reg.tail_bits     <= RST_TAIL_BITS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CARRIER_STEP: cfg_reg.carrier_step  <= cfg_data;
                REG_SYMBOL_LEN:   cfg_reg.symbol_len_q8 <= cfg_data[20:0];
                REG_FRAC_STEP:    cfg_reg.frac_step     <= cfg_data[21:0];
                REG_QPSK_MODE:    cfg_reg.qpsk_mode     <= cfg_data[0];
                REG_INVERT_BITS:  cfg_reg.invert_bits   <= cfg_data[0];
                REG_TAIL_BITS:    cfg_reg.tail_bits     <= cfg_data[7:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    pvm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .append(acc && opcode == OP_APPEND), .char_code(char_code),
        .pop(pop), .qstat(qstat), .refused(refused)
    );

    pvm_sequencer u_seq (
        .clk(clk), .rst_n(rst_n),
        .tick(acc && opcode == OP_TICK), .end_set(acc && opcode == OP_END),
        .cfg(cfg_reg), .qstat(qstat), .pop(pop), .smp(smp),
        .cos_ph(cos_ph), .base(base), .delta(delta), .fin(fin)
    );

    always_comb
    begin
        si.vld    = acc;
        si.smp    = smp;
        si.full   = refused;
        si.fin    = fin;
        si.cos_ph = cos_ph;
        si.base   = base;
        si.delta  = delta;
    end

    pvm_synth u_synth (
        .clk(clk), .rst_n(rst_n), .en(en), .si(si),
        .out_vld(out_valid), .sample(sample), .sample_valid(sample_valid),
        .queue_full(queue_full), .finished(finished)
    );

endmodule

### tb/sv/tb_psk31_varicode_modulator_core.sv
// Testbench for psk31_varicode_modulator_core: drives characters, ticks and end requests,
// predicts every result with a behavioral model of the modulator and checks them in order.
// Depends on pvm_pkg and the modulator RTL.
`timescale 1ns / 100ps

module tb_psk31_varicode_modulator_core;
    import pvm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] sample;
    logic        sample_valid;
    logic        queue_full;
    logic        finished;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    typedef struct {
        logic [15:0] sample;
        logic        sample_valid;
        logic        queue_full;
        logic        finished;
    } mod_result_t;

    mod_result_t pending_results[$];
    int          n_fail;
    int          cycle_count;
    bit          quiet;

    // Model copy of the registers and state.
    logic [31:0] m_carrier_step, m_symbol_len, m_frac_step, m_tail_bits;
    logic        m_qpsk, m_invert;
    logic [7:0]  m_queue[QUEUE_DEPTH];
    int          m_count;
    logic [11:0] m_code;
    int          m_bits_left;
    logic [31:0] m_carrier, m_sym_count, m_frac;
    logic [1:0]  m_start_q, m_step_q;
    int          m_tail_count;
    logic [1:0]  m_pom;
    bit          m_end_req, m_prev_cr, m_loaded;

    psk31_varicode_modulator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .char_code(char_code),
        .out_valid(out_valid), .out_ready(out_ready),
        .sample(sample), .sample_valid(sample_valid),
        .queue_full(queue_full), .finished(finished),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint sine_q30(logic [31:0] ph);
        longint x;
        longint x2;
        longint p;
        x = longint'(ph[29:0]);
        if (ph[30])
            x = longint'(Q30) - x;
        x2 = x * x / longint'(Q30);
        p = longint'(C9);
        p = longint'(C7) + p * x2 / longint'(Q30);
        p = longint'(C5) + p * x2 / longint'(Q30);
        p = longint'(C3) + p * x2 / longint'(Q30);
        p = longint'(C1) + p * x2 / longint'(Q30);
        p = p * x / longint'(Q30);
        if (p > longint'(Q30))
            p = longint'(Q30);
        if (p < 0)
            p = 0;
        return ph[31] ? -p : p;
    endfunction

    function automatic bit next_stream_bit(output bit b);
        logic [9:0] v;
        int len;
        logic [7:0] c;
        if (m_pom == PH_PRE)
        begin
            if (m_tail_count < m_tail_bits)
            begin
                m_tail_count++;
                b = m_invert;
                return 1'b1;
            end
            m_pom = PH_TEXT;
            m_tail_count = 0;
        end
        if (m_pom == PH_TEXT)
        begin
            if (m_bits_left == 0 && m_count > 0)
            begin
                c = m_queue[0];
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    m_queue[i] = m_queue[i + 1];
                m_count--;
                v = c[7] ? 10'd0 : VARICODE[c[6:0]];
                if (v == 0)
                    v = 10'd1;
                len = 0;
                while (len < 12 && (v >> len) != 0)
                    len++;
                m_code = {v, 2'b00};
                m_bits_left = len + 2;
            end
            if (m_bits_left > 0)
            begin
                m_bits_left--;
                b = m_code[m_bits_left] ^ m_invert;
                return 1'b1;
            end
            if (!m_end_req)
            begin
                b = m_invert;
                return 1'b1;
            end
            m_pom = PH_POST;
            m_tail_count = 0;
        end
        if (m_pom == PH_POST)
        begin
            if (m_tail_count < m_tail_bits)
            begin
                m_tail_count++;
                b = m_invert;
                return 1'b1;
            end
            m_pom = PH_DONE;
        end
        return 1'b0;
    endfunction

    function automatic bit load_next_symbol();
        bit a;
        bit b;
        if (!next_stream_bit(a))
            return 1'b0;
        if (m_qpsk)
        begin
            if (!next_stream_bit(b))
                b = 1'b1;
            if (a && b)
                m_step_q = 2'd0;
            else if (!a && b)
                m_step_q = 2'd1;
            else if (a && !b)
                m_step_q = 2'd3;
            else
                m_step_q = 2'd2;
        end
        else
            m_step_q = a ? 2'd0 : 2'd2;
        m_loaded = 1'b1;
        return 1'b1;
    endfunction

    function automatic mod_result_t modulate(logic [1:0] op, logic [7:0] ch);
        mod_result_t r;
        longint cosv, shaped, delta, prod, s, mag, v;
        logic [31:0] ph;
        longint unsigned f;
        r = '{16'd0, 1'b0, 1'b0, 1'b0};
        if (op == OP_APPEND)
        begin
            if (ch == CHAR_LF && m_prev_cr)
                m_prev_cr = 1'b0;
            else if (m_count < QUEUE_DEPTH)
            begin
                m_queue[m_count] = (ch == CHAR_CR) ? CHAR_LF : ch;
                m_count++;
                m_prev_cr = (ch == CHAR_CR);
            end
            else
            begin
                r.queue_full = 1'b1;
                m_prev_cr = 1'b0;
            end
        end
        else if (op == OP_END)
            m_end_req = 1'b1;
        else if (op == OP_TICK && (m_loaded || load_next_symbol()))
        begin
            cosv = sine_q30({m_frac[24:0], 7'b0} + 32'h4000_0000);
            shaped = (longint'(Q30) - cosv) / 2;
            delta = (m_step_q == 2'd3) ? -1 : longint'(m_step_q);
            prod = delta * shaped;
            ph = m_carrier + {m_start_q, 30'b0} + prod[31:0];
            s = sine_q30(ph & PH_MASK);
            mag = (s < 0) ? -s : s;
            v = (mag * 19005 + longint'(Q30) / 2) / longint'(Q30);
            r.sample = (s < 0) ? -v[15:0] : v[15:0];
            r.sample_valid = 1'b1;
            m_carrier = m_carrier + m_carrier_step;
            m_sym_count = m_sym_count + 256;
            m_frac = m_frac + m_frac_step;
            if (m_frac > 32'h0100_0000)
                m_frac = 32'h0100_0000;
            if (m_sym_count >= m_symbol_len)
            begin
                m_start_q = m_start_q + m_step_q;
                m_sym_count = m_sym_count - m_symbol_len;
                if (m_sym_count >= m_symbol_len)
                    m_sym_count = 0;
                f = (longint'(m_sym_count) * longint'(m_frac_step)) >> 8;
                m_frac = (f > 64'h0100_0000) ? 32'h0100_0000 : f[31:0];
                m_loaded = 1'b0;
            end
        end
        r.finished = (m_pom == PH_DONE && !m_loaded);
        return r;
    endfunction

    task automatic send_item(logic [1:0] op, logic [7:0] ch);
        if (!quiet && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        char_code <= ch;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(modulate(op, ch));
    endtask

    // Registers are only written once every result is out and the pipeline is empty.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CARRIER_STEP: m_carrier_step = data;
            REG_SYMBOL_LEN:   m_symbol_len = {11'b0, data[20:0]};
            REG_FRAC_STEP:    m_frac_step = {10'b0, data[21:0]};
            REG_QPSK_MODE:    m_qpsk = data[0];
            REG_INVERT_BITS:  m_invert = data[0];
            REG_TAIL_BITS:    m_tail_bits = {24'b0, data[7:0]};
            default: ;
        endcase
    endtask

    task automatic set_symbol(logic [31:0] len_q8);
        write_reg(REG_SYMBOL_LEN, len_q8);
        write_reg(REG_FRAC_STEP, 32'((64'd1 << 32) / len_q8));
    endtask

    task automatic test_directed();
        write_reg(REG_TAIL_BITS, 32'd3);
        set_symbol(32'd2048);
        repeat (3) send_item(OP_TICK, 8'h00);
        send_item(OP_APPEND, "A");
        send_item(OP_APPEND, CHAR_CR);
        send_item(OP_APPEND, CHAR_LF);
        send_item(OP_APPEND, CHAR_CR);
        send_item(OP_APPEND, "B");
        send_item(OP_APPEND, CHAR_LF);
        send_item(OP_APPEND, 8'h00);
        send_item(OP_APPEND, 8'h7F);
        send_item(OP_APPEND, 8'hFF);
        send_item(OP_UNUSED, 8'hFF);
        repeat (12) send_item(OP_TICK, 8'hFF);
    endtask

    task automatic test_queue_full();
        for (int i = 0; i < 12; i++)
            send_item(OP_APPEND, 8'h61 + i[7:0]);
        send_item(OP_APPEND, CHAR_CR);
        send_item(OP_APPEND, CHAR_LF);
    endtask

    task automatic run_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 3)
                quiet = 1'b1;
            if (i == n / 3 + n / 4)
                quiet = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 72)
                send_item(OP_TICK, 8'($urandom_range(0, 255)));
            else if (r < 80)
                send_item(OP_APPEND, 8'($urandom_range(32, 126)));
            else if (r < 84)
                send_item(OP_APPEND, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            else if (r < 88)
                send_item(OP_APPEND, 8'($urandom_range(0, 255)));
            else
                send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_bpsk_inverted();
        write_reg(REG_INVERT_BITS, 32'd1);
        write_reg(REG_CARRIER_STEP, 32'd0);
        set_symbol(32'd2560);
        run_random(50);
    endtask

    task automatic test_qpsk();
        write_reg(REG_QPSK_MODE, 32'd1);
        write_reg(REG_INVERT_BITS, 32'd0);
        write_reg(REG_CARRIER_STEP, 32'hFFFF_FFFF);
        write_reg(REG_SYMBOL_LEN, 32'd2048);
        write_reg(REG_FRAC_STEP, 32'd2730);
        run_random(40);
        write_reg(REG_INVERT_BITS, 32'd1);
        write_reg(REG_CARRIER_STEP, $urandom);
        set_symbol(32'd3000);
        run_random(40);
    endtask

    task automatic test_long_symbol();
        write_reg(REG_SYMBOL_LEN, 32'd1572864);
        write_reg(REG_FRAC_STEP, 32'd2730);
        run_random(30);
    endtask

    task automatic test_bpsk_plain();
        write_reg(REG_QPSK_MODE, 32'd0);
        write_reg(REG_INVERT_BITS, 32'd0);
        write_reg(REG_TAIL_BITS, 32'd0);
        write_reg(REG_CARRIER_STEP, $urandom);
        write_reg(REG_SYMBOL_LEN, 32'd2048);
        write_reg(REG_FRAC_STEP, 32'd2097152);
        run_random(50);
    endtask

    // Short postamble with an odd bit count in QPSK, then items after the message is done.
    task automatic test_end_of_message();
        write_reg(REG_QPSK_MODE, 32'd1);
        write_reg(REG_TAIL_BITS, 32'd9);
        send_item(OP_END, 8'h00);
        send_item(OP_APPEND, "Z");
        send_item(OP_APPEND, 8'h80);
        while (!(m_pom == PH_DONE && !m_loaded))
            send_item(OP_TICK, 8'($urandom_range(0, 255)));
        repeat (10) send_item(OP_TICK, 8'h00);
        send_item(OP_APPEND, "Q");
        send_item(OP_END, 8'h00);
        send_item(OP_UNUSED, 8'h00);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no item waiting");
                    n_fail++;
                end
                else
                begin
                    mod_result_t e;
                    e = pending_results.pop_front();
                    if (sample !== e.sample)
                    begin
                        $error("sample: expected %0d actual %0d",
                               $signed(e.sample), $signed(sample));
                        n_fail++;
                    end
                    if (sample_valid !== e.sample_valid)
                    begin
                        $error("sample_valid: expected %0b actual %0b",
                               e.sample_valid, sample_valid);
                        n_fail++;
                    end
                    if (queue_full !== e.queue_full)
                    begin
                        $error("queue_full: expected %0b actual %0b", e.queue_full, queue_full);
                        n_fail++;
                    end
                    if (finished !== e.finished)
                    begin
                        $error("finished: expected %0b actual %0b", e.finished, finished);
                        n_fail++;
                    end
                end
            end
            out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        n_fail = 0;
        cycle_count = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_TICK;
        char_code = 8'h00;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = REG_CARRIER_STEP;
        cfg_data = 32'd0;
        m_carrier_step = RST_CARRIER_STEP;
        m_symbol_len = {11'b0, RST_SYMBOL_LEN};
        m_frac_step = {10'b0, RST_FRAC_STEP};
        m_tail_bits = {24'b0, RST_TAIL_BITS};
        m_qpsk = 1'b0;
        m_invert = 1'b0;
        m_count = 0;
        m_code = '0;
        m_bits_left = 0;
        m_carrier = '0;
        m_sym_count = '0;
        m_frac = '0;
        m_start_q = '0;
        m_step_q = '0;
        m_tail_count = 0;
        m_pom = PH_PRE;
        m_end_req = 1'b0;
        m_prev_cr = 1'b0;
        m_loaded = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_queue_full();
        test_bpsk_inverted();
        test_qpsk();
        test_long_symbol();
        test_bpsk_plain();
        test_end_of_message();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
